/* hw/rtl/wsdf_pkg.sv */
// Shared constants for the WebSocket masked frame deframer.
`default_nettype none

package wsdf_pkg;

  // Result kinds carried on m_tuser.
  localparam logic [2:0] KIND_DATA       = 3'd0;
  localparam logic [2:0] KIND_PONG       = 3'd1;
  localparam logic [2:0] KIND_EMPTY_PONG = 3'd2;
  localparam logic [2:0] KIND_CLOSE      = 3'd3;
  localparam logic [2:0] KIND_BAD        = 3'd4;
  localparam logic [2:0] KIND_LONG       = 3'd5;

  // Frame opcodes of interest.
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PING   = 4'd9;

  // Seven-bit length codes that announce an extended length.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Extended length sizes in bytes.
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  localparam int unsigned MAX_PAYLOAD_WIDTH = 25;
  localparam logic [MAX_PAYLOAD_WIDTH-1:0] MAX_PAYLOAD_RESET = 25'd1048576;

endpackage : wsdf_pkg

`default_nettype wire

/* hw/rtl/websocket_masked_frame_deframer.sv */
// Top level of the WebSocket client-to-server masked frame deframer.
// Each result is registered: it appears on the master side in the cycle after the byte that causes it.
// Throughput: one byte per cycle while the master side takes results, set by the single registered parse step
// and the output register, which frees in the same cycle that its result is taken.
// Reset (rst, synchronous): parser returns to header byte zero, halt flag clears, the
// output register empties and max_payload returns to 1048576.
`default_nettype none

module websocket_masked_frame_deframer #(
  parameter int unsigned COUNT_WIDTH = 25
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // Configuration: max_payload write.
  input  wire logic                                   cfg_we,
  input  wire logic [wsdf_pkg::MAX_PAYLOAD_WIDTH-1:0] cfg_data,
  // Slave side, tdata fields from bit 0: in_byte[7:0].
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  input  wire logic [7:0]                             s_tdata,
  // Master side, tdata fields from bit 0: out_byte[7:0].
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  output logic [7:0]                                  m_tdata,
  // tuser fields from bit 0: out_kind[2:0].
  output logic [2:0]                                  m_tuser,
  // tlast carries out_last.
  output logic                                        m_tlast
);

  // Largest length a payload counter of COUNT_WIDTH bits can reach.
  localparam logic [63:0] COUNT_MASK = {64{1'b1}} >> (64 - COUNT_WIDTH);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_MASK,
    PH_DATA
  } phase_t;

  // Parser state.
  phase_t                                 phase, phase_next;
  logic [3:0]                             frame_opcode, frame_opcode_next;
  logic                                   fin_seen, fin_seen_next;
  logic [3:0]                             ext_bytes_left, ext_bytes_left_next;
  logic [63:0]                            frame_length, frame_length_next;
  logic [31:0]                            mask_key, mask_key_next;
  logic [1:0]                             mask_bytes_seen, mask_bytes_seen_next;
  logic [COUNT_WIDTH-1:0]                 payload_index, payload_index_next;
  logic                                   halted, halted_next;
  logic [wsdf_pkg::MAX_PAYLOAD_WIDTH-1:0] max_payload;

  // Result produced by the byte being accepted.
  logic       res_valid;
  logic [7:0] res_byte;
  logic [2:0] res_kind;
  logic       res_last;

  logic                   accept;
  logic [63:0]            limit;
  logic [63:0]            max_payload_ext;
  logic [63:0]            len_cand;
  logic                   len_done;
  logic [COUNT_WIDTH-1:0] index_inc;
  logic                   data_last;
  logic [7:0]             key_byte;

  // The output register takes a new result whenever it is empty or being drained,
  // so the input side never waits on a result that is about to leave.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // The effective length limit is max_payload capped at what the counter can hold.
  assign max_payload_ext = {{(64 - wsdf_pkg::MAX_PAYLOAD_WIDTH){1'b0}}, max_payload};
  assign limit = (max_payload_ext > COUNT_MASK) ? COUNT_MASK : max_payload_ext;

  // Payload position and unmasking. The first key byte sits in the top bits.
  assign index_inc = payload_index + 1'b1;
  assign data_last = (index_inc == frame_length[COUNT_WIDTH-1:0]);

  always_comb begin
    unique case (payload_index[1:0])
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      2'd3: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next           = phase;
    frame_opcode_next    = frame_opcode;
    fin_seen_next        = fin_seen;
    ext_bytes_left_next  = ext_bytes_left;
    frame_length_next    = frame_length;
    mask_key_next        = mask_key;
    mask_bytes_seen_next = mask_bytes_seen;
    payload_index_next   = payload_index;
    halted_next          = halted;
    res_valid            = 1'b0;
    res_byte             = 8'd0;
    res_kind             = wsdf_pkg::KIND_DATA;
    res_last             = 1'b0;
    len_cand             = frame_length;
    len_done             = 1'b0;

    // Once halted, every byte is swallowed without a result.
    if (!halted) begin
      unique case (phase)
        PH_HDR0: begin
          frame_opcode_next = s_tdata[3:0];
          fin_seen_next     = s_tdata[7];
          phase_next        = PH_HDR1;
        end
        PH_HDR1: begin
          if (!s_tdata[7] || !fin_seen) begin
            // Fragmented or unmasked frames are not supported: terminal event.
            halted_next = 1'b1;
            res_valid   = 1'b1;
            res_kind    = wsdf_pkg::KIND_BAD;
            res_last    = 1'b1;
          end else if (s_tdata[6:0] == wsdf_pkg::LEN_EXT16) begin
            frame_length_next   = 64'd0;
            ext_bytes_left_next = wsdf_pkg::EXT16_BYTES;
            phase_next          = PH_EXT;
          end else if (s_tdata[6:0] == wsdf_pkg::LEN_EXT64) begin
            frame_length_next   = 64'd0;
            ext_bytes_left_next = wsdf_pkg::EXT64_BYTES;
            phase_next          = PH_EXT;
          end else begin
            len_cand = {57'd0, s_tdata[6:0]};
            len_done = 1'b1;
          end
        end
        PH_EXT: begin
          // Extended length arrives big-endian.
          len_cand            = {frame_length[55:0], s_tdata};
          ext_bytes_left_next = ext_bytes_left - 4'd1;
          frame_length_next   = len_cand;
          len_done            = (ext_bytes_left == 4'd1);
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], s_tdata};
          if (mask_bytes_seen == 2'd3) begin
            mask_bytes_seen_next = 2'd0;
            payload_index_next   = '0;
            if (frame_length != 64'd0) begin
              phase_next = PH_DATA;
            end else begin
              // Empty frame: close and ping still report an event here.
              phase_next = PH_HDR0;
              if (frame_opcode == wsdf_pkg::OP_CLOSE) begin
                halted_next = 1'b1;
                res_valid   = 1'b1;
                res_kind    = wsdf_pkg::KIND_CLOSE;
                res_last    = 1'b1;
              end else if (frame_opcode == wsdf_pkg::OP_PING) begin
                res_valid = 1'b1;
                res_kind  = wsdf_pkg::KIND_EMPTY_PONG;
                res_last  = 1'b1;
              end
            end
          end else begin
            mask_bytes_seen_next = mask_bytes_seen + 2'd1;
          end
        end
        PH_DATA: begin
          payload_index_next = index_inc;
          if (data_last) begin
            phase_next = PH_HDR0;
          end
          if (frame_opcode == wsdf_pkg::OP_TEXT || frame_opcode == wsdf_pkg::OP_BINARY) begin
            res_valid = 1'b1;
            res_byte  = s_tdata ^ key_byte;
            res_kind  = wsdf_pkg::KIND_DATA;
            res_last  = data_last;
          end else if (frame_opcode == wsdf_pkg::OP_PING) begin
            res_valid = 1'b1;
            res_byte  = s_tdata ^ key_byte;
            res_kind  = wsdf_pkg::KIND_PONG;
            res_last  = data_last;
          end else if (frame_opcode == wsdf_pkg::OP_CLOSE && data_last) begin
            // Close payload is consumed; the event comes with its last byte.
            halted_next = 1'b1;
            res_valid   = 1'b1;
            res_kind    = wsdf_pkg::KIND_CLOSE;
            res_last    = 1'b1;
          end
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase

      // Full length known: check it against the limit, then collect the mask key.
      if (len_done) begin
        frame_length_next = len_cand;
        if (len_cand > limit) begin
          halted_next = 1'b1;
          res_valid   = 1'b1;
          res_kind    = wsdf_pkg::KIND_LONG;
          res_last    = 1'b1;
        end else begin
          mask_key_next        = 32'd0;
          mask_bytes_seen_next = 2'd0;
          phase_next           = PH_MASK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR0;
      frame_opcode    <= 4'd0;
      fin_seen        <= 1'b0;
      ext_bytes_left  <= 4'd0;
      frame_length    <= 64'd0;
      mask_key        <= 32'd0;
      mask_bytes_seen <= 2'd0;
      payload_index   <= '0;
      halted          <= 1'b0;
      max_payload     <= wsdf_pkg::MAX_PAYLOAD_RESET;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_payload <= cfg_data;
      end
      if (accept) begin
        phase           <= phase_next;
        frame_opcode    <= frame_opcode_next;
        fin_seen        <= fin_seen_next;
        ext_bytes_left  <= ext_bytes_left_next;
        frame_length    <= frame_length_next;
        mask_key        <= mask_key_next;
        mask_bytes_seen <= mask_bytes_seen_next;
        payload_index   <= payload_index_next;
        halted          <= halted_next;
        m_tvalid        <= res_valid;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is loaded only with a new result.
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      m_tdata <= res_byte;
      m_tuser <= res_kind;
      m_tlast <= res_last;
    end
  end

endmodule : websocket_masked_frame_deframer

`default_nettype wire
